// ----- rtl/core/adt_pkg.sv -----
// Shared types, codes and constants for the alarm deadline table.
`default_nettype none

package adt_pkg;

    localparam int DEADLINE_W          = 48;
    localparam int ID_W                = 32;
    localparam int FUNC_W              = 2;
    localparam int KIND_W              = 3;
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int MAX_RESULTS         = 16;
    localparam int EMIT_CNT_W          = $clog2(MAX_RESULTS + 1);

    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd4;

    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [ID_W-1:0]       ident;
    } slot_t;

endpackage

`default_nettype wire

// ----- rtl/core/adt_slot_ram.sv -----
// Single-port-write, single-port-read slot memory with registered read data.
`default_nettype none

module adt_slot_ram #(
    parameter int DEPTH = adt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(adt_pkg::DEFAULT_TABLE_DEPTH)
) (
    input  wire logic           aclk,
    input  wire logic           wen,
    input  wire logic [AW-1:0]  waddr,
    input  wire adt_pkg::slot_t wdata,
    input  wire logic           ren,
    input  wire logic [AW-1:0]  raddr,
    output adt_pkg::slot_t      rdata
);

    adt_pkg::slot_t mem [DEPTH];
    adt_pkg::slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while ren is low.
    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/alarm_deadline_table_top.sv -----
// Top level of the alarm deadline table: control, scan engine and result register.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+-----------------
//  s_      | in        | s_func s_is_relative s_time_value s_now_time   | s_valid/s_ready
//          |           | s_alarm_id                                     |
//  m_      | out       | m_kind m_result_id m_last                      | m_valid/m_ready
//
// Register: slot written at the accepting edge; the result is then issued from the FINISH state.
// Cancel and tick: one compaction pass over the live slots through the slot memory,
// reading one slot at a time through the single read port of the memory.
// Reset (aresetn low, synchronous) empties the table and clears the id counter.
// A stalled result channel stalls the tick pass only when a second expired alarm is
// ready to leave; the next transaction is taken once the current one is fully issued.
`default_nettype none

module alarm_deadline_table_top #(
    parameter int TABLE_DEPTH = adt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [adt_pkg::FUNC_W-1:0]         s_func,
    input  wire logic                               s_is_relative,
    input  wire logic [adt_pkg::DEADLINE_W-1:0]     s_time_value,
    input  wire logic [adt_pkg::DEADLINE_W-1:0]     s_now_time,
    input  wire logic [adt_pkg::ID_W-1:0]           s_alarm_id,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [adt_pkg::KIND_W-1:0]              m_kind,
    output logic [adt_pkg::ID_W-1:0]                m_result_id,
    output logic                                    m_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = adt_pkg::EMIT_CNT_W;
    localparam int DW = adt_pkg::DEADLINE_W;
    localparam int IW = adt_pkg::ID_W;
    localparam int KW = adt_pkg::KIND_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] live_count_reg, live_count_next;
    logic [IW-1:0] next_ident_reg, next_ident_next;
    logic          op_tick_reg, op_tick_next;
    logic [IW-1:0] want_reg, want_next;
    logic [DW-1:0] now_reg, now_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] w_reg, w_next;
    logic [NW-1:0] n_reg, n_next;
    logic          found_reg, found_next;
    logic          p_valid_reg, p_valid_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [IW-1:0] pend_id_reg, pend_id_next;
    logic [KW-1:0] fin_kind_reg, fin_kind_next;
    logic [IW-1:0] fin_id_reg, fin_id_next;
    logic          m_valid_reg, m_valid_next;
    logic [KW-1:0] m_kind_reg, m_kind_next;
    logic [IW-1:0] m_id_reg, m_id_next;
    logic          m_last_reg, m_last_next;

    logic           ram_wen, ram_ren;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    adt_pkg::slot_t ram_wdata, ram_rdata;

    logic          out_busy;
    logic          table_full;
    logic [DW:0]   rel_sum;
    logic [DW-1:0] new_deadline;
    logic          drop, emit, stall, more;

    adt_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_slot_ram (
        .aclk  (aclk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_busy   = m_valid_reg && !m_ready;
    assign table_full = (live_count_reg >= CW'(TABLE_DEPTH));
    assign rel_sum    = {1'b0, s_now_time} + {1'b0, s_time_value};
    // Saturate a relative deadline at the top of the time range.
    assign new_deadline = !s_is_relative ? s_time_value :
                          (rel_sum[DW] ? {DW{1'b1}} : rel_sum[DW-1:0]);

    always_comb begin
        drop = 1'b0;
        if (p_valid_reg) begin
            if (op_tick_reg) begin
                drop = (ram_rdata.deadline <= now_reg) &&
                       (n_reg < NW'(adt_pkg::MAX_RESULTS));
            end else begin
                drop = !found_reg && (ram_rdata.ident == want_reg);
            end
        end
        emit  = drop && op_tick_reg;
        stall = emit && pend_valid_reg && out_busy;
        more  = r_reg < live_count_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        live_count_next = live_count_reg;
        next_ident_next = next_ident_reg;
        op_tick_next    = op_tick_reg;
        want_next       = want_reg;
        now_next        = now_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        found_next      = found_reg;
        p_valid_next    = p_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        fin_kind_next   = fin_kind_reg;
        fin_id_next     = fin_id_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;
        ram_wen         = 1'b0;
        ram_waddr       = w_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_ren         = 1'b0;
        ram_raddr       = r_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_func)
                        adt_pkg::FUNC_REGISTER: begin
                            if (table_full) begin
                                fin_kind_next = adt_pkg::KIND_FULL;
                                fin_id_next   = '0;
                            end else begin
                                ram_wen            = 1'b1;
                                ram_waddr          = live_count_reg[AW-1:0];
                                ram_wdata.deadline = new_deadline;
                                ram_wdata.ident    = next_ident_reg;
                                fin_kind_next      = adt_pkg::KIND_REGISTERED;
                                fin_id_next        = next_ident_reg;
                                live_count_next    = live_count_reg + CW'(1);
                                next_ident_next    = next_ident_reg + IW'(1);
                            end
                            state_next = ST_FINISH;
                        end
                        adt_pkg::FUNC_CANCEL, adt_pkg::FUNC_TICK: begin
                            op_tick_next    = (s_func == adt_pkg::FUNC_TICK);
                            want_next       = s_alarm_id;
                            now_next        = s_now_time;
                            r_next          = '0;
                            w_next          = '0;
                            n_next          = '0;
                            found_next      = 1'b0;
                            p_valid_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            // Drop an unknown function code.
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (p_valid_reg && !drop) begin
                        ram_wen = 1'b1;
                        w_next  = w_reg + CW'(1);
                    end
                    if (emit) begin
                        n_next          = n_reg + NW'(1);
                        pend_valid_next = 1'b1;
                        pend_id_next    = ram_rdata.ident;
                        // Release the previous expired alarm; it is not the last one.
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = adt_pkg::KIND_EXPIRED;
                            m_id_next    = pend_id_reg;
                            m_last_next  = 1'b0;
                        end
                    end else if (drop) begin
                        found_next = 1'b1;
                    end
                    ram_ren      = more;
                    p_valid_next = more;
                    if (more) begin
                        r_next = r_reg + CW'(1);
                    end
                    if (!more && !p_valid_reg) begin
                        live_count_next = w_reg;
                        pend_valid_next = 1'b0;
                        if (op_tick_reg) begin
                            fin_kind_next = adt_pkg::KIND_EXPIRED;
                            fin_id_next   = pend_id_reg;
                            state_next    = pend_valid_reg ? ST_FINISH : ST_IDLE;
                        end else begin
                            fin_kind_next = found_reg ? adt_pkg::KIND_CANCELLED
                                                      : adt_pkg::KIND_NOT_FOUND;
                            fin_id_next   = want_reg;
                            state_next    = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = fin_kind_reg;
                    m_id_next    = fin_id_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            live_count_reg <= '0;
            next_ident_reg <= '0;
            p_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            r_reg          <= '0;
            w_reg          <= '0;
            n_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            next_ident_reg <= next_ident_next;
            p_valid_reg    <= p_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            found_reg      <= found_next;
            r_reg          <= r_next;
            w_reg          <= w_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_tick_reg  <= op_tick_next;
        want_reg     <= want_next;
        now_reg      <= now_next;
        pend_id_reg  <= pend_id_next;
        fin_kind_reg <= fin_kind_next;
        fin_id_reg   <= fin_id_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_result_id = m_id_reg;
    assign m_last      = m_last_reg;

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_count_reg <= CW'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(adt_pkg::MAX_RESULTS))
        else $error("tick emitted too many alarms");

    a_write_trails_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (w_reg <= r_reg))
        else $error("compaction write overtook the read pointer");

    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_SCAN))
        else $error("pending expired alarm outside a scan");

    a_register_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == adt_pkg::FUNC_REGISTER) && !table_full)
        |=> (live_count_reg == $past(live_count_reg) + CW'(1)))
        else $error("registration did not add a slot");

endmodule

`default_nettype wire
